// ----- rtl/core/sctm_pkg.sv -----
package sctm_pkg;

  localparam int unsigned SqrtSteps = 64;  // one result bit of the 64-bit root per stage
  localparam int unsigned DivSteps  = 31;  // one quotient bit per stage, quotient below 2^31

  // Per-item side data carried alongside the arithmetic
  typedef struct packed {
    logic        nohit;  // receding, at rest, trajectory miss or late contact
    logic        c_neg;  // spheres already overlap: take the later root
    logic [63:0] bmag;   // |dv.dr|
    logic [63:0] a;      // |dv|^2
    logic [30:0] tmax;   // interval length
  } side_t;

endpackage

// ----- rtl/core/sphere_collision_time_top.sv -----
// Pipeline: 103 register stages from the accepting edge to the result register
//   (6 product/discriminant stages, 64 square-root stages, 33 divide stages).
// Throughput: one request per cycle; every stage advances together and holds
//   while the output register is full and not taken.
// Reset: asynchronous, active low; clears all valid bits, payload is not reset.
module sphere_collision_time_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [31:0] rel_pos_x, [63:32] rel_pos_y, [95:64] rel_pos_z, [127:96] rel_vel_x,
  // [159:128] rel_vel_y, [191:160] rel_vel_z, [222:192] radius_sum,
  // [253:223] interval_len, [255:254] zero
  input  logic [255:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [0] hit, [31:1] contact_time
  output logic [31:0]  m_axis_tdata_o
);
  import sctm_pkg::*;

  logic            en;
  logic [2:0][31:0] rel_pos, rel_vel;
  logic            fr_valid, sq_valid;
  logic [127:0]    disc;
  logic [63:0]     root;
  side_t           fr_side, sq_side;
  logic            hit;
  logic [30:0]     contact_time;

  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  assign rel_pos[0] = s_axis_tdata_i[31:0];
  assign rel_pos[1] = s_axis_tdata_i[63:32];
  assign rel_pos[2] = s_axis_tdata_i[95:64];
  assign rel_vel[0] = s_axis_tdata_i[127:96];
  assign rel_vel[1] = s_axis_tdata_i[159:128];
  assign rel_vel[2] = s_axis_tdata_i[191:160];

  sctm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (s_axis_tvalid_i),
    .rel_pos_i      (rel_pos),
    .rel_vel_i      (rel_vel),
    .radius_sum_i   (s_axis_tdata_i[222:192]),
    .interval_len_i (s_axis_tdata_i[253:223]),
    .valid_o        (fr_valid),
    .disc_o         (disc),
    .side_o         (fr_side)
  );

  sctm_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .disc_i  (disc),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .root_o  (root),
    .side_o  (sq_side)
  );

  sctm_div u_div (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (sq_valid),
    .root_i         (root),
    .side_i         (sq_side),
    .valid_o        (m_axis_tvalid_o),
    .hit_o          (hit),
    .contact_time_o (contact_time)
  );

  assign m_axis_tdata_o = {contact_time, hit};

  a_miss_time_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[31:1] == 31'd0)
    else $error("contact time nonzero on a miss");

  a_stall_freezes_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(fr_valid) && $stable(sq_valid))
    else $error("pipeline moved during a stall");

  a_ready_tracks_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow output stall");

endmodule

// ----- rtl/core/sctm_front.sv -----
module sctm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2:0][31:0]    rel_pos_i,
  input  logic [2:0][31:0]    rel_vel_i,
  input  logic [30:0]         radius_sum_i,
  input  logic [30:0]         interval_len_i,
  output logic                valid_o,
  output logic [127:0]        disc_o,
  output sctm_pkg::side_t     side_o
);
  import sctm_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  // stage 1: component products
  logic signed [63:0] vr1_q [3];
  logic [63:0]        vv1_q [3];
  logic [63:0]        rr1_q [3];
  logic [61:0]        r2_1_q;
  logic [30:0]        tmax1_q;

  // stage 2: dot products
  logic signed [65:0] b2_q;
  logic [63:0]        a2_q;
  logic [63:0]        dr2_2_q;
  logic [61:0]        r2_2_q;
  logic [30:0]        tmax2_q;

  // stage 3: magnitudes and sign of c
  side_t       side3_q;
  logic [63:0] cmag3_q;

  // stage 4: 32x32 partial products of b^2 and a*|c|
  side_t       side4_q;
  logic [63:0] bb00_q, bb01_q, bb11_q;
  logic [63:0] ac00_q, ac01_q, ac10_q, ac11_q;

  // stage 5: full 128-bit products
  side_t        side5_q;
  logic [127:0] bb5_q, ac5_q;

  // stage 6: discriminant
  side_t        side6_q;
  logic [127:0] disc6_q;

  logic [65:0]  bneg;
  logic         c_neg3;
  logic [128:0] diff6;
  side_t        side3_d, side6_d;

  always_comb begin
    bneg           = 66'd0 - b2_q;
    c_neg3         = dr2_2_q < {2'b00, r2_2_q};
    side3_d.nohit  = !b2_q[65] || (a2_q == 64'd0);
    side3_d.c_neg  = c_neg3;
    side3_d.bmag   = bneg[63:0];
    side3_d.a      = a2_q;
    side3_d.tmax   = tmax2_q;
  end

  always_comb begin
    diff6         = {1'b0, bb5_q} - {1'b0, ac5_q};
    side6_d       = side5_q;
    side6_d.nohit = side5_q.nohit || (!side5_q.c_neg && diff6[128]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        vr1_q[k] <= $signed(rel_vel_i[k]) * $signed(rel_pos_i[k]);
        vv1_q[k] <= $signed(rel_vel_i[k]) * $signed(rel_vel_i[k]);
        rr1_q[k] <= $signed(rel_pos_i[k]) * $signed(rel_pos_i[k]);
      end
      r2_1_q  <= radius_sum_i * radius_sum_i;
      tmax1_q <= interval_len_i;

      b2_q    <= {{2{vr1_q[0][63]}}, vr1_q[0]} + {{2{vr1_q[1][63]}}, vr1_q[1]}
               + {{2{vr1_q[2][63]}}, vr1_q[2]};
      a2_q    <= vv1_q[0] + vv1_q[1] + vv1_q[2];
      dr2_2_q <= rr1_q[0] + rr1_q[1] + rr1_q[2];
      r2_2_q  <= r2_1_q;
      tmax2_q <= tmax1_q;

      side3_q <= side3_d;
      cmag3_q <= c_neg3 ? ({2'b00, r2_2_q} - dr2_2_q) : (dr2_2_q - {2'b00, r2_2_q});

      side4_q <= side3_q;
      bb00_q  <= side3_q.bmag[31:0]  * side3_q.bmag[31:0];
      bb01_q  <= side3_q.bmag[31:0]  * side3_q.bmag[63:32];
      bb11_q  <= side3_q.bmag[63:32] * side3_q.bmag[63:32];
      ac00_q  <= side3_q.a[31:0]  * cmag3_q[31:0];
      ac01_q  <= side3_q.a[31:0]  * cmag3_q[63:32];
      ac10_q  <= side3_q.a[63:32] * cmag3_q[31:0];
      ac11_q  <= side3_q.a[63:32] * cmag3_q[63:32];

      side5_q <= side4_q;
      // cross term of the square appears twice
      bb5_q   <= {bb11_q, 64'd0} + {31'd0, bb01_q, 33'd0} + {64'd0, bb00_q};
      ac5_q   <= {ac11_q, 64'd0} + {32'd0, ac01_q, 32'd0} + {32'd0, ac10_q, 32'd0}
               + {64'd0, ac00_q};

      side6_q <= side6_d;
      disc6_q <= side5_q.c_neg ? (bb5_q + ac5_q) : diff6[127:0];
    end
  end

  assign valid_o = v6_q;
  assign disc_o  = disc6_q;
  assign side_o  = side6_q;

endmodule

// ----- rtl/core/sctm_isqrt.sv -----
module sctm_isqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [127:0]    disc_i,
  input  sctm_pkg::side_t side_i,
  output logic            valid_o,
  output logic [63:0]     root_o,
  output sctm_pkg::side_t side_o
);
  import sctm_pkg::*;

  logic         v_q    [SqrtSteps];
  logic [64:0]  rem_q  [SqrtSteps];
  logic [63:0]  root_q [SqrtSteps];
  logic [127:0] n_q    [SqrtSteps];
  side_t        side_q [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    logic         v_in;
    logic [64:0]  rem_in;
    logic [63:0]  root_in;
    logic [127:0] n_in;
    side_t        side_in;
    logic [66:0]  rem_sh, trial, diff;
    logic         ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = disc_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign n_in    = n_q[k-1];
      assign side_in = side_q[k-1];
    end

    // restoring square root: bring down two bits, try 4*root + 1
    assign rem_sh = {rem_in, n_in[127:126]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[64:0] : rem_sh[64:0];
        root_q[k] <= {root_in[62:0], ge};
        n_q[k]    <= {n_in[125:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[SqrtSteps-1];
  assign root_o  = root_q[SqrtSteps-1];
  assign side_o  = side_q[SqrtSteps-1];

endmodule

// ----- rtl/core/sctm_div.sv -----
module sctm_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [63:0]     root_i,
  input  sctm_pkg::side_t side_i,
  output logic            valid_o,
  output logic            hit_o,
  output logic [30:0]     contact_time_o
);
  import sctm_pkg::*;

  // numerator stage
  logic [64:0] num65;
  logic [80:0] num81;
  logic        ovf;

  logic        v0_q, nohit0_q;
  logic [63:0] rem0_q, a0_q;
  logic [30:0] low0_q, tmax0_q;

  logic        v_q     [DivSteps];
  logic        nohit_q [DivSteps];
  logic [63:0] rem_q   [DivSteps];
  logic [63:0] a_q     [DivSteps];
  logic [30:0] low_q   [DivSteps];
  logic [30:0] q_q     [DivSteps];
  logic [30:0] tmax_q  [DivSteps];

  logic        out_v_q, hit_q;
  logic [30:0] time_q;
  logic        hit_d;

  always_comb begin
    num65 = side_i.c_neg ? ({1'b0, side_i.bmag} + {1'b0, root_i})
                         : {1'b0, side_i.bmag - root_i};
    num81 = {num65, 16'd0};
    // quotient of 2^31 or more can never be inside the interval
    ovf   = {14'd0, num81} >= {side_i.a, 31'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nohit0_q <= side_i.nohit || ovf;
      rem0_q   <= {14'd0, num81[80:31]};
      low0_q   <= num81[30:0];
      a0_q     <= side_i.a;
      tmax0_q  <= side_i.tmax;
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic        v_in, nohit_in;
    logic [63:0] rem_in, a_in;
    logic [30:0] low_in, q_in, tmax_in;
    logic [64:0] rem_sh, diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign v_in     = v0_q;
      assign nohit_in = nohit0_q;
      assign rem_in   = rem0_q;
      assign a_in     = a0_q;
      assign low_in   = low0_q;
      assign q_in     = '0;
      assign tmax_in  = tmax0_q;
    end else begin : g_next
      assign v_in     = v_q[k-1];
      assign nohit_in = nohit_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign a_in     = a_q[k-1];
      assign low_in   = low_q[k-1];
      assign q_in     = q_q[k-1];
      assign tmax_in  = tmax_q[k-1];
    end

    assign rem_sh = {rem_in, low_in[30]};
    assign ge     = rem_sh >= {1'b0, a_in};
    assign diff   = rem_sh - {1'b0, a_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nohit_q[k] <= nohit_in;
        rem_q[k]   <= ge ? diff[63:0] : rem_sh[63:0];
        a_q[k]     <= a_in;
        low_q[k]   <= {low_in[29:0], 1'b0};
        q_q[k]     <= {q_in[29:0], ge};
        tmax_q[k]  <= tmax_in;
      end
    end
  end

  assign hit_d = !nohit_q[DivSteps-1] && (q_q[DivSteps-1] <= tmax_q[DivSteps-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= v_q[DivSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q  <= hit_d;
      time_q <= hit_d ? q_q[DivSteps-1] : 31'd0;
    end
  end

  assign valid_o        = out_v_q;
  assign hit_o          = hit_q;
  assign contact_time_o = time_q;

endmodule
